/* hdl/sorted_array_insert_remove_assert.svh */
// Assertion macros shared by the sorted store RTL.
// Every macro samples on the rising edge of i_clk and stays quiet while reset is held.
`ifndef SORTED_ARRAY_INSERT_REMOVE_ASSERT_SVH
`define SORTED_ARRAY_INSERT_REMOVE_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define SAI_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("sorted store check failed");

// The condition must hold in the cycle after the trigger.
`define SAI_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("sorted store check failed");

`endif

/* hdl/sai_pkg.sv */
`default_nettype none

package sai_pkg;

    // Store size and the widths that follow from it.
    localparam int DEPTH    = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int VAL_W    = 32;
    localparam int DUMP_MAX = 16;
    localparam int DUMP_LIM = (DEPTH < DUMP_MAX) ? DEPTH : DUMP_MAX;

    // Field widths of the ports.
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int OIDX_W   = 4;
    localparam int OCNT_W   = 5;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // Commands broadcast to every cell of the chain.
    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_HOLD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ROTATE = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]        code;
        logic signed [VAL_W-1:0] value;
    } t_cell_cmd;

    // What a cell shows its neighbors.
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    occ;
        logic                    ge;
        logic                    seen;
    } t_link;

endpackage

`default_nettype wire

/* hdl/sai_cell.sv */
`default_nettype none

module sai_cell (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire sai_pkg::t_cell_cmd              i_cmd,
    input  wire logic signed [sai_pkg::VAL_W-1:0] i_head,
    input  wire sai_pkg::t_link                  i_left,
    input  wire sai_pkg::t_link                  i_right,
    output sai_pkg::t_link                       o_link
);
    import sai_pkg::*;

    logic signed [VAL_W-1:0] r_value;
    logic                    r_occ;
    logic                    w_ge;
    logic                    w_match;

    // An empty cell or one not smaller than the new word marks the insert point.
    always_comb begin
        w_ge    = !r_occ || ($signed(r_value) >= $signed(i_cmd.value));
        w_match = r_occ && (r_value == i_cmd.value);
        o_link.value = r_value;
        o_link.occ   = r_occ;
        o_link.ge    = w_ge;
        o_link.seen  = i_left.seen || w_match;
    end

    // Stored entry: shift up, shift down, rotate toward the head, or load.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.code)
            CMD_INSERT: begin
                if (i_left.ge) begin
                    r_value <= i_left.value;
                end else if (w_ge) begin
                    r_value <= i_cmd.value;
                end
            end
            CMD_REMOVE: begin
                if (i_left.seen || w_match) begin
                    r_value <= i_right.value;
                end
            end
            CMD_ROTATE: begin
                if (i_right.occ) begin
                    r_value <= i_right.value;
                end else if (r_occ) begin
                    r_value <= i_head;
                end
            end
            default: begin
                r_value <= r_value;
            end
        endcase
    end

    // Occupied flag; the occupied cells always form a run from the head.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            unique case (i_cmd.code)
                CMD_CLEAR:  r_occ <= 1'b0;
                CMD_INSERT: r_occ <= r_occ || i_left.occ;
                CMD_REMOVE: r_occ <= i_right.occ;
                default:    r_occ <= r_occ;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/sorted_array_insert_remove.sv */
// Channel  Direction  Handshake               Payload
// in       input      i_in_valid / o_in_stall  i_op, i_value
// out      output     o_out_valid / i_out_stall o_status, o_entry_value, o_entry_index,
//                                              o_entry_valid, o_count_after, o_last
//
// Clear, insert and remove act on the whole cell chain in the accepting cycle; the word
// appears in the next cycle, and the next item may be taken while it leaves if the output is not stalled.
// A dump of n entries rotates the chain once per cycle while the output is not stalled,
// giving one word per rotation, with no new item taken until the rotation ends.
// Synchronous active-low reset empties the store and holds the input stalled.
// A stall on the output holds the word and freezes the dump rotation.
`default_nettype none

module sorted_array_insert_remove (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic [sai_pkg::OP_W-1:0]             i_op,
    input  wire logic signed [sai_pkg::VAL_W-1:0]     i_value,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic [sai_pkg::STATUS_W-1:0]              o_status,
    output logic signed [sai_pkg::VAL_W-1:0]          o_entry_value,
    output logic [sai_pkg::OIDX_W-1:0]                o_entry_index,
    output logic                                      o_entry_valid,
    output logic [sai_pkg::OCNT_W-1:0]                o_count_after,
    output logic                                      o_last
);
    import sai_pkg::*;

    `include "sorted_array_insert_remove_assert.svh"

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_busy;
    logic [IDX_W-1:0]        r_idx;
    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_out_status;
    logic signed [VAL_W-1:0] r_out_value;
    logic [OIDX_W-1:0]       r_out_index;
    logic                    r_out_evalid;
    logic [OCNT_W-1:0]       r_out_count;
    logic                    r_out_last;

    logic                    w_out_free;
    logic                    w_in_acc;
    logic                    w_step;
    logic                    w_found;
    logic                    w_dump_last;
    logic [CNT_W-1:0]        w_idx_ext;
    logic [STATUS_W-1:0]     w_status;
    t_cell_cmd               w_cmd;
    t_link                   w_link [DEPTH];
    t_link                   w_left [DEPTH];
    t_link                   w_right [DEPTH];
    logic [DEPTH-1:0]        w_occ_vec;

    // Handshake: one item at a time, and only when the output word can move.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !i_rst_n || r_busy || !w_out_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_step     = r_busy && w_out_free;
    assign w_found    = w_link[DEPTH-1].seen;

    // Neighbor wiring with fixed ends of the chain.
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            if (k == 0) begin
                w_left[k] = '{value: '0, occ: 1'b1, ge: 1'b0, seen: 1'b0};
            end else begin
                w_left[k] = w_link[k-1];
            end
            if (k == DEPTH - 1) begin
                w_right[k] = '{value: '0, occ: 1'b0, ge: 1'b0, seen: 1'b0};
            end else begin
                w_right[k] = w_link[k+1];
            end
            w_occ_vec[k] = w_link[k].occ;
        end
    end

    // The chain of cells.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        sai_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_head  (w_link[0].value),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .o_link  (w_link[g])
        );
    end

    // Command, new count and status for the accepted item.
    always_comb begin
        w_cmd.value = i_value;
        w_cmd.code  = CMD_HOLD;
        n_count     = r_count;
        w_status    = ST_OK;
        if (w_in_acc) begin
            unique case (i_op)
                OP_CLEAR: begin
                    w_cmd.code = CMD_CLEAR;
                    n_count    = '0;
                end
                OP_INSERT: begin
                    if (r_count == CNT_W'(DEPTH)) begin
                        w_status = ST_FULL;
                    end else begin
                        w_cmd.code = CMD_INSERT;
                        n_count    = r_count + 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (r_count == '0) begin
                        w_status = ST_EMPTY;
                    end else if (!w_found) begin
                        w_status = ST_NOT_FOUND;
                    end else begin
                        w_cmd.code = CMD_REMOVE;
                        n_count    = r_count - 1'b1;
                    end
                end
                default: begin
                    if (r_count == '0) begin
                        w_status = ST_EMPTY;
                    end
                end
            endcase
        end else if (w_step) begin
            w_cmd.code = CMD_ROTATE;
        end
    end

    // Dump position tracking.
    assign w_idx_ext   = CNT_W'(r_idx);
    assign w_dump_last = (w_idx_ext == r_count - 1'b1) || (w_idx_ext == CNT_W'(DUMP_LIM - 1));

    // Control registers: count, dump flag and dump position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_count <= n_count;
            if (w_in_acc && (i_op == OP_DUMP) && (r_count != '0)) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (w_step) begin
                if (w_idx_ext == r_count - 1'b1) begin
                    r_busy <= 1'b0;
                end
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Output word valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= !((i_op == OP_DUMP) && (r_count != '0));
        end else if (w_step) begin
            r_out_valid <= (w_idx_ext < CNT_W'(DUMP_LIM));
        end else if (w_out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output word payload.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out_status <= w_status;
            r_out_value  <= '0;
            r_out_index  <= '0;
            r_out_evalid <= 1'b0;
            r_out_count  <= OCNT_W'(n_count);
            r_out_last   <= 1'b1;
        end else if (w_step && (w_idx_ext < CNT_W'(DUMP_LIM))) begin
            r_out_status <= ST_OK;
            r_out_value  <= w_link[0].value;
            r_out_index  <= OIDX_W'(r_idx);
            r_out_evalid <= 1'b1;
            r_out_count  <= OCNT_W'(r_count);
            r_out_last   <= w_dump_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_value = r_out_value;
    assign o_entry_index = r_out_index;
    assign o_entry_valid = r_out_evalid;
    assign o_count_after = r_out_count;
    assign o_last        = r_out_last;

    // The occupied cells always agree with the entry count.
    `SAI_ASSERT_SAME(a_occ_count, 1'b1, $countones(w_occ_vec) == r_count)
    // A dump in progress always has entries to rotate.
    `SAI_ASSERT_SAME(a_busy_nonempty, r_busy, r_count != '0)
    // Every accepted item leaves either a word or a running dump behind.
    `SAI_ASSERT_NEXT(a_acc_progress, w_in_acc, r_out_valid || r_busy)
    // A full store never grows past its depth.
    `SAI_ASSERT_SAME(a_count_range, 1'b1, r_count <= CNT_W'(DEPTH))

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import sai_pkg::*;

    localparam int RANDOM_ITEMS = 350;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    // One result word as it leaves the block.
    typedef struct {
        logic [STATUS_W-1:0]     status;
        logic signed [VAL_W-1:0] value;
        logic [OIDX_W-1:0]       index;
        logic                    valid;
        logic [OCNT_W-1:0]       count;
        logic                    last;
    } t_result_word;

    // One row of the directed table; typed rows carry their own status and count.
    typedef struct {
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] value;
        bit                      typed;
        logic [STATUS_W-1:0]     status;
        logic [OCNT_W-1:0]       count;
    } t_stim_row;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic [OP_W-1:0]         in_op     = OP_CLEAR;
    logic signed [VAL_W-1:0] in_value  = '0;
    logic                    out_stall = 1'b0;

    wire logic                    in_stall;
    wire logic                    out_valid;
    wire logic [STATUS_W-1:0]     out_status;
    wire logic signed [VAL_W-1:0] out_entry_value;
    wire logic [OIDX_W-1:0]       out_entry_index;
    wire logic                    out_entry_valid;
    wire logic [OCNT_W-1:0]       out_count_after;
    wire logic                    out_last;

    // Shadow copy of the sorted store and the words it is expected to emit.
    logic signed [VAL_W-1:0] model_entries [DEPTH];
    int                      model_count = 0;
    t_result_word            expected_words [$];
    t_stim_row               directed_rows [$];

    int  mismatches = 0;
    int  cycles     = 0;
    int  words_sent = 0;
    bit  send_quiet = 1'b0;

    sorted_array_insert_remove dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_op          (in_op),
        .i_value       (in_value),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_status      (out_status),
        .o_entry_value (out_entry_value),
        .o_entry_index (out_entry_index),
        .o_entry_valid (out_entry_valid),
        .o_count_after (out_count_after),
        .o_last        (out_last)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Runaway guard.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_result_word make_word(logic [STATUS_W-1:0] status,
                                               logic signed [VAL_W-1:0] value,
                                               int index, logic valid, logic last);
        t_result_word w;
        w.status = status;
        w.value  = value;
        w.index  = index[OIDX_W-1:0];
        w.valid  = valid;
        w.count  = model_count[OCNT_W-1:0];
        w.last   = last;
        return w;
    endfunction

    // Apply one operation to the shadow store and queue the words it causes.
    task automatic predict_store_op(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] value);
        int                  pos;
        int                  n;
        logic [STATUS_W-1:0] status;
        status = ST_OK;
        case (op)
            OP_CLEAR: begin
                model_count = 0;
            end
            OP_INSERT: begin
                if (model_count >= DEPTH) begin
                    status = ST_FULL;
                end else begin
                    // New value goes ahead of any equal entries.
                    pos = 0;
                    while (pos < model_count && model_entries[pos] < value) pos++;
                    for (int i = model_count; i > pos; i--)
                        model_entries[i] = model_entries[i-1];
                    model_entries[pos] = value;
                    model_count++;
                end
            end
            OP_REMOVE: begin
                if (model_count == 0) begin
                    status = ST_EMPTY;
                end else begin
                    pos = 0;
                    while (pos < model_count && model_entries[pos] != value) pos++;
                    if (pos == model_count) begin
                        status = ST_NOT_FOUND;
                    end else begin
                        for (int i = pos; i + 1 < model_count; i++)
                            model_entries[i] = model_entries[i+1];
                        model_count--;
                    end
                end
            end
            default: begin
                // A dump streams the entries in order, or one empty word.
                if (model_count == 0) begin
                    expected_words.push_back(make_word(ST_EMPTY, '0, 0, 1'b0, 1'b1));
                end else begin
                    n = (model_count > DUMP_MAX) ? DUMP_MAX : model_count;
                    for (int i = 0; i < n; i++)
                        expected_words.push_back(make_word(ST_OK, model_entries[i], i,
                                                           1'b1, i + 1 == n));
                end
                return;
            end
        endcase
        expected_words.push_back(make_word(status, '0, 0, 1'b0, 1'b1));
    endtask

    function automatic t_stim_row stim_row(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] value,
                                           bit typed, logic [STATUS_W-1:0] status, int count);
        t_stim_row r;
        r.op     = op;
        r.value  = value;
        r.typed  = typed;
        r.status = status;
        r.count  = count[OCNT_W-1:0];
        return r;
    endfunction

    // Mix of extremes, small clustered values, held values and full-range values.
    function automatic logic signed [VAL_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        if (sel <= 3)
            return $signed(32'($urandom_range(0, 16))) - 32'sd8;
        if (sel <= 5 && model_count > 0)
            return model_entries[$urandom_range(0, model_count - 1)];
        return $urandom;
    endfunction

    // Present one word on the input channel; called and returning at a falling edge.
    task automatic send_word(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] value);
        int gap;
        if (words_sent % 40 == 0) send_quiet = ($urandom_range(0, 3) == 0);
        gap = send_quiet ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_value <= value;
        do @(posedge clk); while (in_stall);
        predict_store_op(op, value);
        words_sent++;
        @(negedge clk);
    endtask

    // Output side back-pressure: a random stall ahead of each accepted word.
    initial begin : receiver
        int  hold;
        int  taken;
        bit  quiet;
        taken = 0;
        quiet = 1'b0;
        forever begin
            @(negedge clk);
            if (taken % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
            hold = quiet ? 0 : $urandom_range(0, 4);
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    task automatic check_field(string name, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // Compare each accepted output word with the oldest expectation.
    always @(posedge clk) begin : scoreboard
        t_result_word exp_w;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual status %0d value %0h",
                         $time, out_status, out_entry_value);
                mismatches++;
            end else begin
                exp_w = expected_words.pop_front();
                check_field("status", exp_w.status, out_status);
                check_field("entry_value", exp_w.value, out_entry_value);
                check_field("entry_index", exp_w.index, out_entry_index);
                check_field("entry_valid", exp_w.valid, out_entry_valid);
                check_field("count_after", exp_w.count, out_count_after);
                check_field("last", exp_w.last, out_last);
            end
        end
    end

    initial begin : stimulus
        t_result_word    typed_w;
        logic [OP_W-1:0] op;
        logic signed [VAL_W-1:0] value;
        int              r;
        bit              grow;

        // Directed table: empty store, extremes, equal values, full, absent value.
        directed_rows.push_back(stim_row(OP_DUMP,   32'sd0,         1, ST_EMPTY, 0));
        directed_rows.push_back(stim_row(OP_REMOVE, 32'sd5,         1, ST_EMPTY, 0));
        directed_rows.push_back(stim_row(OP_INSERT, 32'sh7fffffff,  1, ST_OK, 1));
        directed_rows.push_back(stim_row(OP_INSERT, 32'sh80000000,  1, ST_OK, 2));
        directed_rows.push_back(stim_row(OP_INSERT, 32'sd0,         1, ST_OK, 3));
        directed_rows.push_back(stim_row(OP_INSERT, 32'sd0,         1, ST_OK, 4));
        directed_rows.push_back(stim_row(OP_INSERT, -32'sd1,        1, ST_OK, 5));
        directed_rows.push_back(stim_row(OP_INSERT, -32'sd5,        0, ST_OK, 0));
        directed_rows.push_back(stim_row(OP_INSERT, 32'sd7,         0, ST_OK, 0));
        directed_rows.push_back(stim_row(OP_INSERT, 32'sd3,         0, ST_OK, 0));
        directed_rows.push_back(stim_row(OP_INSERT, 32'sd3,         0, ST_OK, 0));
        directed_rows.push_back(stim_row(OP_INSERT, -32'sd100,      0, ST_OK, 0));
        directed_rows.push_back(stim_row(OP_INSERT, 32'sd100000,    0, ST_OK, 0));
        directed_rows.push_back(stim_row(OP_INSERT, -32'sd2,        0, ST_OK, 0));
        directed_rows.push_back(stim_row(OP_INSERT, 32'sd2,         0, ST_OK, 0));
        directed_rows.push_back(stim_row(OP_INSERT, 32'sd1000,      0, ST_OK, 0));
        directed_rows.push_back(stim_row(OP_INSERT, -32'sd1000,     0, ST_OK, 0));
        directed_rows.push_back(stim_row(OP_INSERT, 32'sd42,        0, ST_OK, 0));
        directed_rows.push_back(stim_row(OP_INSERT, 32'sd9,         1, ST_FULL, 16));
        directed_rows.push_back(stim_row(OP_DUMP,   32'sh55aa55aa,  0, ST_OK, 0));
        directed_rows.push_back(stim_row(OP_REMOVE, 32'sd12345,     1, ST_NOT_FOUND, 16));
        directed_rows.push_back(stim_row(OP_REMOVE, 32'sh80000000,  1, ST_OK, 15));
        directed_rows.push_back(stim_row(OP_REMOVE, 32'sh7fffffff,  1, ST_OK, 14));
        directed_rows.push_back(stim_row(OP_REMOVE, 32'sd0,         0, ST_OK, 0));
        directed_rows.push_back(stim_row(OP_DUMP,   -32'sd1,        0, ST_OK, 0));
        directed_rows.push_back(stim_row(OP_CLEAR,  32'sh7fffffff,  1, ST_OK, 0));
        directed_rows.push_back(stim_row(OP_DUMP,   32'sh80000000,  1, ST_EMPTY, 0));

        // Hold synchronous reset, then release it.
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[k]) begin
            send_word(directed_rows[k].op, directed_rows[k].value);
            if (directed_rows[k].typed) begin
                typed_w = expected_words.pop_back();
                typed_w.status = directed_rows[k].status;
                typed_w.value  = '0;
                typed_w.index  = '0;
                typed_w.valid  = 1'b0;
                typed_w.count  = directed_rows[k].count;
                typed_w.last   = 1'b1;
                expected_words.push_back(typed_w);
            end
        end

        // Random part: random stretches that tend to fill or drain the store.
        grow = 1'b1;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 60 == 0) grow = $urandom_range(0, 1);
            r = $urandom_range(0, 99);
            if (r < 2)
                op = OP_CLEAR;
            else if (r < 12)
                op = OP_DUMP;
            else if (r < (grow ? 82 : 37))
                op = OP_INSERT;
            else
                op = OP_REMOVE;
            if (op == OP_REMOVE && model_count > 0 && $urandom_range(0, 9) < 6)
                value = model_entries[$urandom_range(0, model_count - 1)];
            else
                value = pick_value();
            send_word(op, value);
        end
        in_valid <= 1'b0;

        // Drain the outstanding words, then let the block idle before the verdict.
        while (expected_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
